/* sv/matrix_multiply_core_macros.svh */
// assertion macros shared by the matrix multiply core modules
`ifndef MATRIX_MULTIPLY_CORE_MACROS_SVH
`define MATRIX_MULTIPLY_CORE_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked on every rising edge outside reset
`define MMC_ASSERT_IMPLY(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("matrix_multiply_core check failed");
// next-cycle implication
`define MMC_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("matrix_multiply_core check failed");
`else
`define MMC_ASSERT_IMPLY(label, clk, rst, pre, post)
`define MMC_ASSERT_NEXT(label, clk, rst, pre, post)
`endif

`endif

/* sv/mmc_pkg.sv */
// shared constants and types of the matrix multiply core
`default_nettype none
package mmc_pkg;

   // parameter defaults
   localparam int DEFAULT_MAX_DIM       = 8;
   localparam int DEFAULT_ELEMENT_WIDTH = 16;

   // fixed field widths
   localparam int MODE_WIDTH    = 2;
   localparam int INDEX_WIDTH   = 3;
   localparam int VALUE_WIDTH   = 16;
   localparam int PRODUCT_WIDTH = 36;
   localparam int DIM_WIDTH     = 4;

   // stream data widths, padded to whole bytes
   localparam int REQ_DATA_WIDTH  = 24;
   localparam int RSP_DATA_WIDTH  = 48;

   // configuration port
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 4;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_LEFT_ROWS  = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_INNER_SIZE = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_RIGHT_COLS = 2'd2;

   localparam logic [DIM_WIDTH-1:0] DIM_RESET = 4'd8;

   // item kinds
   localparam logic [MODE_WIDTH-1:0] MODE_LOAD_LEFT  = 2'd0;
   localparam logic [MODE_WIDTH-1:0] MODE_LOAD_RIGHT = 2'd1;
   localparam logic [MODE_WIDTH-1:0] MODE_COMPUTE    = 2'd2;

   // tag that follows each issued term through the datapath
   typedef struct packed {
      logic                   valid;
      logic                   first;
      logic                   last_term;
      logic                   last_elem;
      logic [INDEX_WIDTH-1:0] row;
      logic [INDEX_WIDTH-1:0] col;
   } term_tag_type;

   // datapath status seen by the sequencer
   typedef struct packed {
      logic out_free;
      logic elem_done;
   } dp_status_type;

endpackage
`default_nettype wire

/* sv/mmc_ram.sv */
// generic simple dual-port ram with registered read
`default_nettype none
module mmc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

/* sv/mmc_sequencer.sv */
// item intake, store writes and row/column/term walk of a compute run
`default_nettype none
`include "matrix_multiply_core_macros.svh"
module mmc_sequencer #(
   parameter int MAX_DIM       = mmc_pkg::DEFAULT_MAX_DIM,
   parameter int ELEMENT_WIDTH = mmc_pkg::DEFAULT_ELEMENT_WIDTH,
   localparam int IDX_W        = $clog2(MAX_DIM),
   localparam int AW           = $clog2(MAX_DIM * MAX_DIM)
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [mmc_pkg::MODE_WIDTH-1:0]      req_mode,
   input  wire logic [mmc_pkg::INDEX_WIDTH-1:0]     req_row,
   input  wire logic [mmc_pkg::INDEX_WIDTH-1:0]     req_col,
   input  wire logic [mmc_pkg::VALUE_WIDTH-1:0]     req_value,
   input  wire logic [mmc_pkg::DIM_WIDTH-1:0]       left_rows,
   input  wire logic [mmc_pkg::DIM_WIDTH-1:0]       inner_size,
   input  wire logic [mmc_pkg::DIM_WIDTH-1:0]       right_cols,
   input  wire mmc_pkg::dp_status_type              status,
   output logic                                     left_wr_en,
   output logic                                     right_wr_en,
   output logic [AW-1:0]                            wr_addr,
   output logic [ELEMENT_WIDTH-1:0]                 wr_data,
   output logic                                     rd_en,
   output logic [AW-1:0]                            left_rd_addr,
   output logic [AW-1:0]                            right_rd_addr,
   output mmc_pkg::term_tag_type                    tag
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_HOLD  = 2'd1;
   localparam logic [1:0] ST_RUN   = 2'd2;
   localparam logic [1:0] ST_DRAIN = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [IDX_W-1:0] i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic [IDX_W-1:0] nr_ff, nr_in, nk_ff, nk_in, nc_ff, nc_in;
   logic             accept, in_range, last_term, last_elem;

   // zero counts as one, anything above the store size saturates
   function automatic logic [IDX_W-1:0] last_index(input logic [mmc_pkg::DIM_WIDTH-1:0] v);
      logic [mmc_pkg::DIM_WIDTH:0] t;
      begin
         if (v == '0) begin
            t = (mmc_pkg::DIM_WIDTH+1)'(1);
         end else if (int'(v) > MAX_DIM) begin
            t = (mmc_pkg::DIM_WIDTH+1)'(MAX_DIM);
         end else begin
            t = {1'b0, v};
         end
         return IDX_W'(t - (mmc_pkg::DIM_WIDTH+1)'(1));
      end
   endfunction

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign in_range  = (int'(req_row) < MAX_DIM) && (int'(req_col) < MAX_DIM);

   // loads write straight into the stores; a compute starts reading later
   assign wr_addr     = AW'(int'(req_row) * MAX_DIM + int'(req_col));
   assign wr_data     = ELEMENT_WIDTH'($unsigned(req_value));
   assign left_wr_en  = accept && in_range && (req_mode == mmc_pkg::MODE_LOAD_LEFT);
   assign right_wr_en = accept && in_range && (req_mode == mmc_pkg::MODE_LOAD_RIGHT);

   assign last_term = (k_ff == nk_ff);
   assign last_elem = (i_ff == nr_ff) && (j_ff == nc_ff);

   assign rd_en         = (state_ff == ST_RUN);
   assign left_rd_addr  = AW'(int'(i_ff) * MAX_DIM + int'(k_ff));
   assign right_rd_addr = AW'(int'(k_ff) * MAX_DIM + int'(j_ff));

   always_comb begin
      tag.valid     = (state_ff == ST_RUN);
      tag.first     = (k_ff == '0);
      tag.last_term = last_term;
      tag.last_elem = last_elem;
      tag.row       = mmc_pkg::INDEX_WIDTH'(i_ff);
      tag.col       = mmc_pkg::INDEX_WIDTH'(j_ff);
   end

   always_comb begin
      state_in = state_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      k_in     = k_ff;
      nr_in    = nr_ff;
      nk_in    = nk_ff;
      nc_in    = nc_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_mode == mmc_pkg::MODE_COMPUTE)) begin
               nr_in    = last_index(left_rows);
               nk_in    = last_index(inner_size);
               nc_in    = last_index(right_cols);
               i_in     = '0;
               j_in     = '0;
               k_in     = '0;
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (status.out_free) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (last_term) begin
               state_in = ST_DRAIN;
            end else begin
               k_in = k_ff + IDX_W'(1);
            end
         end
         ST_DRAIN: begin
            if (status.elem_done) begin
               k_in = '0;
               if (last_elem) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_HOLD;
                  if (j_ff == nc_ff) begin
                     j_in = '0;
                     i_in = i_ff + IDX_W'(1);
                  end else begin
                     j_in = j_ff + IDX_W'(1);
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      i_ff  <= i_in;
      j_ff  <= j_in;
      k_ff  <= k_in;
      nr_ff <= nr_in;
      nk_ff <= nk_in;
      nc_ff <= nc_in;
   end

   `MMC_ASSERT_NEXT(a_run_ends_in_drain, clock, reset, (state_ff == ST_RUN) && last_term, state_ff == ST_DRAIN)
   `MMC_ASSERT_IMPLY(a_writes_only_idle, clock, reset, left_wr_en || right_wr_en, state_ff == ST_IDLE)
   `MMC_ASSERT_IMPLY(a_done_only_drain, clock, reset, status.elem_done, state_ff == ST_DRAIN)

endmodule
`default_nettype wire

/* sv/mmc_datapath.sv */
// multiply-accumulate pipeline and result register
`default_nettype none
`include "matrix_multiply_core_macros.svh"
module mmc_datapath #(
   parameter int ELEMENT_WIDTH = mmc_pkg::DEFAULT_ELEMENT_WIDTH
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire mmc_pkg::term_tag_type               tag,
   input  wire logic [ELEMENT_WIDTH-1:0]            left_rdata,
   input  wire logic [ELEMENT_WIDTH-1:0]            right_rdata,
   output mmc_pkg::dp_status_type                   status,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [mmc_pkg::PRODUCT_WIDTH-1:0]        rsp_value,
   output logic [mmc_pkg::INDEX_WIDTH-1:0]          rsp_row,
   output logic [mmc_pkg::INDEX_WIDTH-1:0]          rsp_col,
   output logic                                     rsp_last
);

   mmc_pkg::term_tag_type tag1_ff, tag2_ff;
   logic signed [2*ELEMENT_WIDTH-1:0] product_in, product_ff;
   logic [mmc_pkg::PRODUCT_WIDTH-1:0] acc_ff, sum_in;
   logic [mmc_pkg::PRODUCT_WIDTH-1:0] out_value_ff;
   logic [mmc_pkg::INDEX_WIDTH-1:0]   out_row_ff, out_col_ff;
   logic                              out_last_ff, out_valid_ff, land;

   // tag1 lines up with the store read data
   assign product_in = $signed(left_rdata) * $signed(right_rdata);

   // running sum wraps at the output width
   assign sum_in = (tag2_ff.first ? '0 : acc_ff)
                   + mmc_pkg::PRODUCT_WIDTH'(product_ff);
   assign land   = tag2_ff.valid && tag2_ff.last_term;

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff.valid <= 1'b0;
         tag2_ff.valid <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         tag1_ff <= tag;
         tag2_ff <= tag1_ff;
         if (land) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
      product_ff <= product_in;
      if (tag2_ff.valid) begin
         acc_ff <= sum_in;
      end
      if (land) begin
         out_value_ff <= sum_in;
         out_row_ff   <= tag2_ff.row;
         out_col_ff   <= tag2_ff.col;
         out_last_ff  <= tag2_ff.last_elem;
      end
   end

   assign status.out_free  = !out_valid_ff || rsp_ready;
   assign status.elem_done = land;

   assign rsp_valid = out_valid_ff;
   assign rsp_value = out_value_ff;
   assign rsp_row   = out_row_ff;
   assign rsp_col   = out_col_ff;
   assign rsp_last  = out_last_ff;

   `MMC_ASSERT_IMPLY(a_land_into_empty, clock, reset, land, !out_valid_ff)
   `MMC_ASSERT_NEXT(a_land_shows, clock, reset, land, out_valid_ff)

endmodule
`default_nettype wire

/* sv/matrix_multiply_core.sv */
// top level of the matrix multiply core
`default_nettype none
// Matrix multiply core: holds a left and a right matrix of signed Q8.8
// elements in two on-chip stores of MAX_DIM x MAX_DIM entries and multiplies
// them on request. A word with tuser = load left or load right writes one
// element at its row and column; rows or columns beyond the store are
// dropped. A compute word walks the product in row-major order and returns
// one word per element with the exact Q20.16 dot product (wrapping at 36
// bits), its row and column, and tlast on the final element. The dimensions
// come from three registers (zero counts as one, values above MAX_DIM
// saturate). One multiply-accumulate unit fed by one read port per store
// produces every element: for each one it waits to claim the result
// register, reads both stores once per inner term, then drains the pipeline.
// No new word is taken while a run is in progress, but the last result may
// still wait in its register while the next loads come in. Store contents
// are undefined until loaded, and there is no clearing pass after reset. The
// registers must be written only while the core is idle; the core itself
// does not enforce this.
module matrix_multiply_core #(
   parameter int MAX_DIM       = mmc_pkg::DEFAULT_MAX_DIM,
   parameter int ELEMENT_WIDTH = mmc_pkg::DEFAULT_ELEMENT_WIDTH
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // request stream
   input  wire logic                                  req_tvalid,
   output logic                                       req_tready,
   // row_index [2:0], col_index [5:3], element_value [21:6], zero pad [23:22]
   input  wire logic [mmc_pkg::REQ_DATA_WIDTH-1:0]    req_tdata,
   // mode [1:0]
   input  wire logic [mmc_pkg::MODE_WIDTH-1:0]        req_tuser,
   // response stream
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   // product_value [35:0], out_row [38:36], out_col [41:39], zero pad [47:42]
   output logic [mmc_pkg::RSP_DATA_WIDTH-1:0]         rsp_tdata,
   output logic                                       rsp_tlast,
   // register write port
   input  wire logic                                  csr_we,
   input  wire logic [mmc_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  wire logic [mmc_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata
);

   localparam int DEPTH = MAX_DIM * MAX_DIM;
   localparam int AW    = $clog2(DEPTH);
   localparam int IW    = mmc_pkg::INDEX_WIDTH;
   localparam int PW    = mmc_pkg::PRODUCT_WIDTH;

   // dimension registers
   logic [mmc_pkg::DIM_WIDTH-1:0] left_rows_ff, inner_size_ff, right_cols_ff;

   // request fields
   logic [IW-1:0]                     req_row, req_col;
   logic [mmc_pkg::VALUE_WIDTH-1:0]   req_value;

   // store ports
   logic                     left_wr_en, right_wr_en, rd_en;
   logic [AW-1:0]            wr_addr, left_rd_addr, right_rd_addr;
   logic [ELEMENT_WIDTH-1:0] wr_data, left_rdata, right_rdata;

   mmc_pkg::term_tag_type    tag;
   mmc_pkg::dp_status_type   status;

   // result fields
   logic [PW-1:0] rsp_value;
   logic [IW-1:0] rsp_row, rsp_col;

   assign req_row   = req_tdata[IW-1:0];
   assign req_col   = req_tdata[2*IW-1:IW];
   assign req_value = req_tdata[2*IW+mmc_pkg::VALUE_WIDTH-1:2*IW];

   // index beyond the three registers writes nothing
   always_ff @(posedge clock) begin
      if (reset) begin
         left_rows_ff  <= mmc_pkg::DIM_RESET;
         inner_size_ff <= mmc_pkg::DIM_RESET;
         right_cols_ff <= mmc_pkg::DIM_RESET;
      end else if (csr_we) begin
         case (csr_index)
            mmc_pkg::REG_LEFT_ROWS:  left_rows_ff  <= csr_wdata;
            mmc_pkg::REG_INNER_SIZE: inner_size_ff <= csr_wdata;
            mmc_pkg::REG_RIGHT_COLS: right_cols_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // control: intake, store writes, read address walk
   mmc_sequencer #(
      .MAX_DIM       (MAX_DIM),
      .ELEMENT_WIDTH (ELEMENT_WIDTH)
   ) u_sequencer (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_tvalid),
      .req_ready     (req_tready),
      .req_mode      (req_tuser),
      .req_row       (req_row),
      .req_col       (req_col),
      .req_value     (req_value),
      .left_rows     (left_rows_ff),
      .inner_size    (inner_size_ff),
      .right_cols    (right_cols_ff),
      .status        (status),
      .left_wr_en    (left_wr_en),
      .right_wr_en   (right_wr_en),
      .wr_addr       (wr_addr),
      .wr_data       (wr_data),
      .rd_en         (rd_en),
      .left_rd_addr  (left_rd_addr),
      .right_rd_addr (right_rd_addr),
      .tag           (tag)
   );

   // left matrix store, addressed row * MAX_DIM + col
   mmc_ram #(
      .WIDTH (ELEMENT_WIDTH),
      .DEPTH (DEPTH)
   ) u_left_store (
      .clock   (clock),
      .wr_en   (left_wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (left_rd_addr),
      .rd_data (left_rdata)
   );

   // right matrix store, same addressing
   mmc_ram #(
      .WIDTH (ELEMENT_WIDTH),
      .DEPTH (DEPTH)
   ) u_right_store (
      .clock   (clock),
      .wr_en   (right_wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (right_rd_addr),
      .rd_data (right_rdata)
   );

   // multiply, accumulate, hold the result word
   mmc_datapath #(
      .ELEMENT_WIDTH (ELEMENT_WIDTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .tag         (tag),
      .left_rdata  (left_rdata),
      .right_rdata (right_rdata),
      .status      (status),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_value   (rsp_value),
      .rsp_row     (rsp_row),
      .rsp_col     (rsp_col),
      .rsp_last    (rsp_tlast)
   );

   assign rsp_tdata = {{(mmc_pkg::RSP_DATA_WIDTH - PW - 2*IW){1'b0}},
                       rsp_col, rsp_row, rsp_value};

endmodule
`default_nettype wire

/* bench/matrix_multiply_core_tb.sv */
`timescale 1ns / 1ps
// self-checking bench for the matrix multiply core: loads, computes and product word checks
module matrix_multiply_core_tb;
   import mmc_pkg::*;

   localparam int STORE_DIM = DEFAULT_MAX_DIM;
   localparam int STORE_DEPTH = STORE_DIM * STORE_DIM;
   // the one request kind the core drops silently
   localparam logic [MODE_WIDTH-1:0] MODE_UNUSED = 2'd3;
   localparam int REQ_FIELD_BITS = 2 * INDEX_WIDTH + VALUE_WIDTH;
   localparam int RANDOM_ITEMS = 350;
   // loads write the store as soon as they are taken, so this settle time is plenty before a register write
   localparam int SETTLE_CYCLES = 8;
   localparam int CYCLE_LIMIT = 1_000_000;

   // one expected product word
   typedef struct packed {
      logic [PRODUCT_WIDTH-1:0] product;
      logic [INDEX_WIDTH-1:0]   row;
      logic [INDEX_WIDTH-1:0]   col;
      logic                     last;
   } product_word_type;

   // shadow of the core: dimension registers, both element stores and the
   // queue of product words still owed by the core
   class product_scoreboard;
      logic [DIM_WIDTH-1:0]          dim_reg [3];
      logic signed [VALUE_WIDTH-1:0] left_elem [STORE_DEPTH];
      logic signed [VALUE_WIDTH-1:0] right_elem [STORE_DEPTH];
      product_word_type              owed_q [$];
      int                            errors;

      function new();
         dim_reg = '{DIM_RESET, DIM_RESET, DIM_RESET};
         foreach (left_elem[n]) begin
            left_elem[n] = '0;
            right_elem[n] = '0;
         end
         errors = 0;
      endfunction

      // zero counts as one, anything above the store size saturates
      static function int clamp_dim(logic [DIM_WIDTH-1:0] v);
         if (v == 0) begin
            return 1;
         end
         if (v > STORE_DIM) begin
            return STORE_DIM;
         end
         return int'(v);
      endfunction

      function void write_dim(logic [CSR_INDEX_WIDTH-1:0] idx, logic [DIM_WIDTH-1:0] v);
         if (idx <= REG_RIGHT_COLS) begin
            dim_reg[idx] = v;
         end
      endfunction

      function void note_input(logic [MODE_WIDTH-1:0] mode, logic [INDEX_WIDTH-1:0] row,
                               logic [INDEX_WIDTH-1:0] col, logic [VALUE_WIDTH-1:0] value);
         int               nr;
         int               nk;
         int               nc;
         longint           acc;
         product_word_type word;
         case (mode)
            MODE_LOAD_LEFT: begin
               left_elem[row * STORE_DIM + col] = value;
            end
            MODE_LOAD_RIGHT: begin
               right_elem[row * STORE_DIM + col] = value;
            end
            MODE_COMPUTE: begin
               nr = clamp_dim(dim_reg[REG_LEFT_ROWS]);
               nk = clamp_dim(dim_reg[REG_INNER_SIZE]);
               nc = clamp_dim(dim_reg[REG_RIGHT_COLS]);
               for (int i = 0; i < nr; i++) begin
                  for (int j = 0; j < nc; j++) begin
                     acc = 0;
                     for (int k = 0; k < nk; k++) begin
                        acc += longint'(left_elem[i * STORE_DIM + k]) *
                               longint'(right_elem[k * STORE_DIM + j]);
                     end
                     word.product = acc[PRODUCT_WIDTH-1:0];
                     word.row = i[INDEX_WIDTH-1:0];
                     word.col = j[INDEX_WIDTH-1:0];
                     word.last = (i == nr - 1) && (j == nc - 1);
                     owed_q.insert(owed_q.size(), word);
                  end
               end
            end
            default: begin
            end
         endcase
      endfunction

      task report(string what, logic [PRODUCT_WIDTH-1:0] got, logic [PRODUCT_WIDTH-1:0] want);
         $display("%0t: %s mismatch, got %h expected %h", $realtime, what, got, want);
         errors++;
      endtask

      task check_result(logic [RSP_DATA_WIDTH-1:0] data, logic last);
         product_word_type want;
         if (owed_q.size() == 0) begin
            report("unexpected word, product", data[PRODUCT_WIDTH-1:0], '0);
         end else begin
            want = owed_q.pop_front();
            if (data[PRODUCT_WIDTH-1:0] !== want.product) begin
               report("product", data[PRODUCT_WIDTH-1:0], want.product);
            end
            if (data[PRODUCT_WIDTH +: INDEX_WIDTH] !== want.row) begin
               report("row", data[PRODUCT_WIDTH +: INDEX_WIDTH], want.row);
            end
            if (data[PRODUCT_WIDTH + INDEX_WIDTH +: INDEX_WIDTH] !== want.col) begin
               report("col", data[PRODUCT_WIDTH + INDEX_WIDTH +: INDEX_WIDTH], want.col);
            end
            if (last !== want.last) begin
               report("tlast", last, want.last);
            end
         end
      endtask
   endclass

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;
   always #5 clock = ~clock;

   // core inputs, known from time zero
   logic                         req_tvalid = 1'b0;
   logic [REQ_DATA_WIDTH-1:0]    req_tdata = '0;
   logic [MODE_WIDTH-1:0]        req_tuser = '0;
   logic                         rsp_tready = 1'b0;
   logic                         csr_we = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0]   csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]    csr_wdata = '0;

   // core outputs
   logic                         req_tready;
   logic                         rsp_tvalid;
   logic [RSP_DATA_WIDTH-1:0]    rsp_tdata;
   logic                         rsp_tlast;

   product_scoreboard sb;

   // which store entries hold a value, so a compute never reads an unwritten one
   bit left_loaded [STORE_DEPTH];
   bit right_loaded [STORE_DEPTH];

   // idle rates in percent, changed per phase
   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   int items_sent = 0;
   int cycle_count = 0;

   matrix_multiply_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // mostly random Q8.8 values, with the corners showing up often
   function automatic logic [VALUE_WIDTH-1:0] rand_element();
      case ($urandom_range(9))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'h0000;
         3: return 16'hffff;
         default: return VALUE_WIDTH'($urandom);
      endcase
   endfunction

   // dimension register value: mostly small, with zero and oversize values mixed in
   function automatic logic [DIM_WIDTH-1:0] pick_dim();
      int r;
      r = $urandom_range(99);
      if (r < 10) begin
         return 4'd0;
      end else if (r < 20) begin
         return DIM_WIDTH'($urandom_range(15, 9));
      end else if (r < 28) begin
         return 4'd8;
      end
      return DIM_WIDTH'($urandom_range(4, 1));
   endfunction

   // present one request word and hold it until the core takes it
   task send_word(logic [MODE_WIDTH-1:0] mode, logic [INDEX_WIDTH-1:0] row,
                  logic [INDEX_WIDTH-1:0] col, logic [VALUE_WIDTH-1:0] value);
      // sender gaps, one decision per cycle
      while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= mode;
      req_tdata <= {{(REQ_DATA_WIDTH - REQ_FIELD_BITS){1'b0}}, value, col, row};
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      // taken at this edge
      sb.note_input(mode, row, col, value);
      if (mode == MODE_LOAD_LEFT) begin
         left_loaded[row * STORE_DIM + col] = 1'b1;
      end else if (mode == MODE_LOAD_RIGHT) begin
         right_loaded[row * STORE_DIM + col] = 1'b1;
      end
      if (mode != MODE_UNUSED) begin
         items_sent++;
      end
   endtask

   // stop sending until every owed product word is back, then let the core settle
   task wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.owed_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // write all three dimension registers back to back
   task program_dims(logic [DIM_WIDTH-1:0] rows, logic [DIM_WIDTH-1:0] inner,
                     logic [DIM_WIDTH-1:0] cols);
      logic [DIM_WIDTH-1:0] dims [3];
      dims = '{rows, inner, cols};
      for (int n = 0; n < 3; n++) begin
         csr_we <= 1'b1;
         csr_index <= CSR_INDEX_WIDTH'(n);
         csr_wdata <= dims[n];
         @(posedge clock);
         sb.write_dim(CSR_INDEX_WIDTH'(n), dims[n]);
      end
      csr_we <= 1'b0;
   endtask

   // load every operand entry the active sizes read; with extreme set, overwrite them all
   // with full-scale values, else only fill entries never written
   task load_operands(bit extreme);
      int nr;
      int nk;
      int nc;
      nr = product_scoreboard::clamp_dim(sb.dim_reg[REG_LEFT_ROWS]);
      nk = product_scoreboard::clamp_dim(sb.dim_reg[REG_INNER_SIZE]);
      nc = product_scoreboard::clamp_dim(sb.dim_reg[REG_RIGHT_COLS]);
      for (int i = 0; i < nr; i++) begin
         for (int k = 0; k < nk; k++) begin
            if (extreme || !left_loaded[i * STORE_DIM + k]) begin
               send_word(MODE_LOAD_LEFT, INDEX_WIDTH'(i), INDEX_WIDTH'(k),
                         extreme ? 16'h8000 : rand_element());
            end
         end
      end
      for (int k = 0; k < nk; k++) begin
         for (int j = 0; j < nc; j++) begin
            // odd columns come out as large negative sums
            if (extreme || !right_loaded[k * STORE_DIM + j]) begin
               send_word(MODE_LOAD_RIGHT, INDEX_WIDTH'(k), INDEX_WIDTH'(j),
                         extreme ? (j[0] ? 16'h7fff : 16'h8000) : rand_element());
            end
         end
      end
   endtask

   // compute word with noise in the ignored fields, operands made complete first
   task send_compute();
      load_operands(1'b0);
      send_word(MODE_COMPUTE, INDEX_WIDTH'($urandom), INDEX_WIDTH'($urandom),
                VALUE_WIDTH'($urandom));
   endtask

   // one segment: loads anywhere in the stores, computes and dropped words
   task run_segment(int n_items);
      int r;
      int row_span;
      int col_span;
      logic [MODE_WIDTH-1:0] mode;
      for (int n = 0; n < n_items; n++) begin
         r = $urandom_range(99);
         if (r < 6) begin
            send_word(MODE_UNUSED, INDEX_WIDTH'($urandom), INDEX_WIDTH'($urandom),
                      VALUE_WIDTH'($urandom));
         end else if (r < 18) begin
            send_compute();
         end else begin
            mode = $urandom_range(1) ? MODE_LOAD_RIGHT : MODE_LOAD_LEFT;
            if (mode == MODE_LOAD_LEFT) begin
               row_span = product_scoreboard::clamp_dim(sb.dim_reg[REG_LEFT_ROWS]);
               col_span = product_scoreboard::clamp_dim(sb.dim_reg[REG_INNER_SIZE]);
            end else begin
               row_span = product_scoreboard::clamp_dim(sb.dim_reg[REG_INNER_SIZE]);
               col_span = product_scoreboard::clamp_dim(sb.dim_reg[REG_RIGHT_COLS]);
            end
            // a share of loads lands outside the active sizes but inside the store
            if ($urandom_range(99) < 30) begin
               row_span = STORE_DIM;
               col_span = STORE_DIM;
            end
            send_word(mode, INDEX_WIDTH'($urandom_range(row_span - 1)),
                      INDEX_WIDTH'($urandom_range(col_span - 1)), rand_element());
         end
      end
      // every segment ends on a compute so its loads get used
      send_compute();
   endtask

   // result side: check each taken word, then decide the next cycle's tready
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            sb.check_result(rsp_tdata, rsp_tlast);
         end
         rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      int random_start;
      bit first_segment;
      sb = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: single-element product with the corners of Q8.8
      program_dims(4'd1, 4'd1, 4'd1);
      send_word(MODE_LOAD_LEFT, 3'd0, 3'd0, 16'h8000);
      send_word(MODE_LOAD_RIGHT, 3'd0, 3'd0, 16'h8000);
      send_word(MODE_COMPUTE, 3'd7, 3'd7, 16'hffff);
      send_word(MODE_LOAD_RIGHT, 3'd0, 3'd0, 16'h7fff);
      send_word(MODE_COMPUTE, 3'd0, 3'd0, 16'h0000);
      // loads outside the active size are kept but must not change the product
      send_word(MODE_LOAD_LEFT, 3'd7, 3'd7, 16'h7fff);
      send_word(MODE_LOAD_RIGHT, 3'd7, 3'd7, 16'hffff);
      send_word(MODE_LOAD_LEFT, 3'd0, 3'd7, 16'h0001);
      // unused kind is dropped with no word back
      send_word(MODE_UNUSED, 3'd7, 3'd7, 16'h5555);
      send_word(MODE_COMPUTE, 3'd5, 3'd2, 16'haaaa);

      // zero in every dimension register acts as one
      wait_idle();
      program_dims(4'd0, 4'd0, 4'd0);
      send_word(MODE_LOAD_LEFT, 3'd0, 3'd0, 16'h0100);
      send_word(MODE_LOAD_RIGHT, 3'd0, 3'd0, 16'hff00);
      send_word(MODE_COMPUTE, 3'd0, 3'd0, 16'h0000);
      send_word(MODE_LOAD_LEFT, 3'd0, 3'd0, 16'h0000);
      send_word(MODE_COMPUTE, 3'd0, 3'd0, 16'h0000);

      // random part in three idling phases; every segment starts from an idle core
      random_start = items_sent;
      first_segment = 1'b1;
      while (items_sent - random_start < RANDOM_ITEMS) begin
         if (items_sent - random_start < 170) begin
            tx_idle_pct = 29;
            rx_idle_pct = 70;
         end else if (items_sent - random_start < 260) begin
            tx_idle_pct = 70;
            rx_idle_pct = 29;
         end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end
         wait_idle();
         if (first_segment) begin
            // full size with an oversize inner register and full-scale operands
            program_dims(4'd8, 4'd15, 4'd8);
            load_operands(1'b1);
            send_compute();
            first_segment = 1'b0;
         end else begin
            program_dims(pick_dim(), pick_dim(), pick_dim());
            run_segment($urandom_range(30, 10));
         end
      end

      // drain, then a short quiet tail
      wait_idle();
      if (sb.errors == 0 && sb.owed_q.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
